// File: src/obstacle_aware_pd_steering_top_assert.svh
// assertion macros for the obstacle-aware pd steering block
// the using module must have clk and rst_n (asynchronous, active low) in scope
`ifndef OBSTACLE_AWARE_PD_STEERING_TOP_ASSERT_SVH
`define OBSTACLE_AWARE_PD_STEERING_TOP_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define OAPDS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define OAPDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/oapds_pkg.sv
// shared types, widths and constants of the obstacle-aware pd steering block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package oapds_pkg;

    // field and datapath widths
    localparam int AREA_W      = 18;
    localparam int X_W         = 10;
    localparam int GAIN_W      = 16;
    localparam int ERR_W       = 20;
    localparam int WALL_ERR_W  = 19;
    localparam int BLOB_ERR_W  = 11;
    localparam int MUL_A_W     = 18;
    localparam int MUL_B_W     = 30;
    localparam int ACC_W       = 48;
    localparam int WEIGHT_W    = 17;
    localparam int DIFF_W      = 12;
    localparam int ANGLE_W     = 7;
    localparam int PULSE_W     = 11;
    localparam int SPEED_W     = 8;
    localparam int MODE_W      = 2;
    localparam int CLEAR_W     = 4;

    // bus widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    // defaults of the top-level parameters
    localparam int HOLD_FRAMES_DEF     = 8;
    localparam int CENTER_ANGLE_DEF    = 90;
    localparam int RED_THRESHOLD_DEF   = 900;
    localparam int GREEN_THRESHOLD_DEF = 2200;

    // steering constants
    localparam int ANGLE_LOW   = 80;
    localparam int ANGLE_HIGH  = 110;
    localparam int FULL_SPEED  = 200;
    localparam int SPEED_DROP  = 60;
    localparam int WEIGHT_ONE  = 65536;
    localparam int WEIGHT_SPAN = 2500;
    localparam int WEIGHT_FRAC = 16;
    localparam int CLEAR_MAX   = 15;
    localparam int WALL_FRAC   = 16;
    localparam int AVOID_FRAC  = 32;

    // reciprocal of the weight span, 2^32 / 2500 rounded down
    localparam longint WEIGHT_RECIP = (64'sd1 <<< 32) / WEIGHT_SPAN;

    // servo pulse: base + angle * num / den
    localparam int PULSE_BASE = 500;
    localparam int PULSE_NUM  = 2500;
    localparam int PULSE_DEN  = 180;

    // register reset values
    localparam logic [GAIN_W-1:0] WALL_GAIN_P_RST  = 16'd459;
    localparam logic [GAIN_W-1:0] WALL_GAIN_D_RST  = 16'd1311;
    localparam logic [GAIN_W-1:0] RED_GAIN_P_RST   = 16'd26214;
    localparam logic [GAIN_W-1:0] RED_GAIN_D_RST   = 16'd9830;
    localparam logic [GAIN_W-1:0] GREEN_GAIN_P_RST = 16'd655;
    localparam logic [GAIN_W-1:0] GREEN_GAIN_D_RST = 16'd0;
    localparam logic [X_W-1:0]    RED_TARGET_RST   = 10'd60;
    localparam logic [X_W-1:0]    GREEN_TARGET_RST = 10'd584;

    // steering modes
    typedef enum logic [MODE_W-1:0] {
        MODE_WALL,
        MODE_RED,
        MODE_GREEN
    } steer_mode_t;

    // register indexes, byte address 4 * index
    typedef enum logic [2:0] {
        REG_WALL_GAIN_P,
        REG_WALL_GAIN_D,
        REG_RED_GAIN_P,
        REG_RED_GAIN_D,
        REG_GREEN_GAIN_P,
        REG_GREEN_GAIN_D,
        REG_RED_TARGET_X,
        REG_GREEN_TARGET_X
    } reg_index_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL_P,
        S_MUL_D,
        S_ADD_D,
        S_W_EST,
        S_W_BACK,
        S_W_FIX,
        S_MUL_W,
        S_MUL_S,
        S_SPEED,
        S_CLAMP,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] wall_gain_p;
        logic [GAIN_W-1:0] wall_gain_d;
        logic [GAIN_W-1:0] red_gain_p;
        logic [GAIN_W-1:0] red_gain_d;
        logic [GAIN_W-1:0] green_gain_p;
        logic [GAIN_W-1:0] green_gain_d;
        logic [X_W-1:0]    red_target_x;
        logic [X_W-1:0]    green_target_x;
    } cfg_t;

    typedef struct packed {
        logic [AREA_W-1:0] left_wall_area;
        logic [AREA_W-1:0] right_wall_area;
        logic [AREA_W-1:0] red_area;
        logic [X_W-1:0]    red_x;
        logic [AREA_W-1:0] green_area;
        logic [X_W-1:0]    green_x;
    } in_item_t;

    typedef struct packed {
        steer_mode_t         mode;
        logic [ANGLE_W-1:0]  angle;
        logic [SPEED_W-1:0]  speed;
        logic [WEIGHT_W-1:0] weight;
    } res_t;

    // operands of the shared multiplier, both taken as signed
    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_op_t;

endpackage

// File: src/obstacle_aware_pd_steering_top.sv
// Obstacle-aware PD steering. Each input request carries one camera frame's wall
// areas and largest red and green blobs; each produces exactly one command with
// mode, servo angle (80..110), servo pulse, motor speed and proximity weight.
// Each request runs as a sequence of products through the single shared
// multiplier: two for the PD terms in both modes and, in avoid mode only, two
// for the weight division by reciprocal and two for weighting and speed. The
// next request can be accepted in the cycle after the result is taken. One
// request is processed at a time: s_axis_tready is high only while the sequencer
// is idle, and a result waiting in the output register holds the sequencer until
// it is taken.
// Gains and targets are written over the APB port; the user must write them only
// while no request is in work, which the block itself does not enforce.
// depends on oapds_pkg, oapds_cfg, oapds_mul, oapds_seq
`timescale 1ns / 1ps

module obstacle_aware_pd_steering_top
    import oapds_pkg::*;
#(
    parameter int HOLD_FRAMES     = HOLD_FRAMES_DEF,
    parameter int CENTER_ANGLE    = CENTER_ANGLE_DEF,
    parameter int RED_THRESHOLD   = RED_THRESHOLD_DEF,
    parameter int GREEN_THRESHOLD = GREEN_THRESHOLD_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // left_wall_area, right_wall_area, red_area, red_x, green_area, green_x
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // steer_mode, steer_angle, servo_pulse_us, motor_speed, proximity_weight
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int PULSE_ENTRIES = 2 ** 5;
    localparam int PAD_W = OUT_TDATA_W - (MODE_W + ANGLE_W + PULSE_W + SPEED_W + WEIGHT_W);

    cfg_t                    cfg;
    in_item_t                item;
    res_t                    res;
    logic                    res_valid;
    logic                    res_ready;
    mul_op_t                 mul_op;
    logic signed [ACC_W-1:0] mul_prod;
    logic [PULSE_W-1:0]      pulse_tab [PULSE_ENTRIES];
    logic [4:0]              pulse_idx;
    logic [PULSE_W-1:0]      pulse;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    // input unpacking, first field in the lowest bits
    assign item.left_wall_area  = s_axis_tdata[17:0];
    assign item.right_wall_area = s_axis_tdata[35:18];
    assign item.red_area        = s_axis_tdata[53:36];
    assign item.red_x           = s_axis_tdata[63:54];
    assign item.green_area      = s_axis_tdata[81:64];
    assign item.green_x         = s_axis_tdata[91:82];

    oapds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    oapds_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (mul_prod)
    );

    oapds_seq #(
        .HOLD_FRAMES     (HOLD_FRAMES),
        .CENTER_ANGLE    (CENTER_ANGLE),
        .RED_THRESHOLD   (RED_THRESHOLD),
        .GREEN_THRESHOLD (GREEN_THRESHOLD)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mul_op    (mul_op),
        .mul_prod  (mul_prod)
    );

    // servo pulse table indexed by angle above the lower clamp
    for (genvar g = 0; g < PULSE_ENTRIES; g++)
    begin : g_pulse
        assign pulse_tab[g] = PULSE_W'(PULSE_BASE + ((ANGLE_LOW + g) * PULSE_NUM) / PULSE_DEN);
    end

    assign pulse_idx = 5'(res.angle - ANGLE_W'(ANGLE_LOW));
    assign pulse     = pulse_tab[pulse_idx];

    // output register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        priority if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= {PAD_W'(0), res.weight, res.speed, pulse, res.angle, res.mode};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: src/oapds_cfg.sv
// apb register file holding the loop gains and blob targets
// depends on oapds_pkg
`timescale 1ns / 1ps

module oapds_cfg
    import oapds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wall_gain_p    <= WALL_GAIN_P_RST;
            cfg_reg.wall_gain_d    <= WALL_GAIN_D_RST;
            cfg_reg.red_gain_p     <= RED_GAIN_P_RST;
            cfg_reg.red_gain_d     <= RED_GAIN_D_RST;
            cfg_reg.green_gain_p   <= GREEN_GAIN_P_RST;
            cfg_reg.green_gain_d   <= GREEN_GAIN_D_RST;
            cfg_reg.red_target_x   <= RED_TARGET_RST;
            cfg_reg.green_target_x <= GREEN_TARGET_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_WALL_GAIN_P:    cfg_reg.wall_gain_p    <= pwdata[GAIN_W-1:0];
                REG_WALL_GAIN_D:    cfg_reg.wall_gain_d    <= pwdata[GAIN_W-1:0];
                REG_RED_GAIN_P:     cfg_reg.red_gain_p     <= pwdata[GAIN_W-1:0];
                REG_RED_GAIN_D:     cfg_reg.red_gain_d     <= pwdata[GAIN_W-1:0];
                REG_GREEN_GAIN_P:   cfg_reg.green_gain_p   <= pwdata[GAIN_W-1:0];
                REG_GREEN_GAIN_D:   cfg_reg.green_gain_d   <= pwdata[GAIN_W-1:0];
                REG_RED_TARGET_X:   cfg_reg.red_target_x   <= pwdata[X_W-1:0];
                REG_GREEN_TARGET_X: cfg_reg.green_target_x <= pwdata[X_W-1:0];
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (index)
            REG_WALL_GAIN_P:    prdata = APB_DATA_W'(cfg_reg.wall_gain_p);
            REG_WALL_GAIN_D:    prdata = APB_DATA_W'(cfg_reg.wall_gain_d);
            REG_RED_GAIN_P:     prdata = APB_DATA_W'(cfg_reg.red_gain_p);
            REG_RED_GAIN_D:     prdata = APB_DATA_W'(cfg_reg.red_gain_d);
            REG_GREEN_GAIN_P:   prdata = APB_DATA_W'(cfg_reg.green_gain_p);
            REG_GREEN_GAIN_D:   prdata = APB_DATA_W'(cfg_reg.green_gain_d);
            REG_RED_TARGET_X:   prdata = APB_DATA_W'(cfg_reg.red_target_x);
            REG_GREEN_TARGET_X: prdata = APB_DATA_W'(cfg_reg.green_target_x);
        endcase
    end

endmodule

// File: src/oapds_mul.sv
// shared signed multiplier with a registered product
// depends on oapds_pkg
`timescale 1ns / 1ps

module oapds_mul
    import oapds_pkg::*;
(
    input  logic                    clk,
    input  mul_op_t                 op,
    output logic signed [ACC_W-1:0] prod
);

    logic signed [MUL_A_W-1:0] a_s;
    logic signed [MUL_B_W-1:0] b_s;
    logic signed [ACC_W-1:0]   prod_reg;

    assign a_s  = op.a;
    assign b_s  = op.b;
    assign prod = prod_reg;

    // one product per cycle, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= a_s * b_s;
    end

endmodule

// File: src/oapds_seq.sv
// sequencer and datapath: obstacle decision, pd loops, weight, speed and clamp
// depends on oapds_pkg, drives the shared multiplier oapds_mul
`timescale 1ns / 1ps
`include "obstacle_aware_pd_steering_top_assert.svh"

module oapds_seq
    import oapds_pkg::*;
#(
    parameter int HOLD_FRAMES     = HOLD_FRAMES_DEF,
    parameter int CENTER_ANGLE    = CENTER_ANGLE_DEF,
    parameter int RED_THRESHOLD   = RED_THRESHOLD_DEF,
    parameter int GREEN_THRESHOLD = GREEN_THRESHOLD_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_item_t                in_item,
    output logic                    res_valid,
    input  logic                    res_ready,
    output res_t                    res,
    output mul_op_t                 mul_op,
    input  logic signed [ACC_W-1:0] mul_prod
);

    localparam int REM_W = DIFF_W + WEIGHT_FRAC + 1;

    localparam logic [CLEAR_W-1:0]  HOLD      = CLEAR_W'(HOLD_FRAMES);
    localparam logic [CLEAR_W-1:0]  CLEAR_TOP = CLEAR_W'(CLEAR_MAX);
    localparam logic [AREA_W-1:0]   RED_THR   = AREA_W'(RED_THRESHOLD);
    localparam logic [AREA_W-1:0]   GREEN_THR = AREA_W'(GREEN_THRESHOLD);
    localparam logic [AREA_W-1:0]   SPAN_AREA = AREA_W'(WEIGHT_SPAN);
    localparam logic [REM_W-1:0]    SPAN_REM  = REM_W'(WEIGHT_SPAN);
    localparam logic [MUL_B_W-1:0]  RECIP_B   = MUL_B_W'(WEIGHT_RECIP);
    localparam logic [MUL_B_W-1:0]  SPAN_B    = MUL_B_W'(WEIGHT_SPAN);
    localparam logic [MUL_B_W-1:0]  DROP_B    = MUL_B_W'(SPEED_DROP);
    localparam logic [WEIGHT_W-1:0] W_MAX     = WEIGHT_W'(WEIGHT_ONE);
    localparam logic [SPEED_W-1:0]  FULL      = SPEED_W'(FULL_SPEED);
    localparam logic [SPEED_W-1:0]  SLOWEST   = SPEED_W'(FULL_SPEED - SPEED_DROP);
    localparam logic [ANGLE_W-1:0]  A_LOW     = ANGLE_W'(ANGLE_LOW);
    localparam logic [ANGLE_W-1:0]  A_HIGH    = ANGLE_W'(ANGLE_HIGH);

    localparam logic signed [ACC_W-1:0] WALL_BASE  = ACC_W'(CENTER_ANGLE) <<< WALL_FRAC;
    localparam logic signed [ACC_W-1:0] AVOID_BASE = ACC_W'(CENTER_ANGLE) <<< AVOID_FRAC;
    localparam logic signed [ACC_W-1:0] LO_WALL    = ACC_W'(ANGLE_LOW) <<< WALL_FRAC;
    localparam logic signed [ACC_W-1:0] HI_WALL    = ACC_W'(ANGLE_HIGH) <<< WALL_FRAC;
    localparam logic signed [ACC_W-1:0] LO_AVOID   = ACC_W'(ANGLE_LOW) <<< AVOID_FRAC;
    localparam logic signed [ACC_W-1:0] HI_AVOID   = ACC_W'(ANGLE_HIGH) <<< AVOID_FRAC;

    // control state
    seq_state_t                     state_reg, state_next;
    logic                           avoid_reg, avoid_next;
    logic                           red_latch_reg, red_latch_next;
    logic [CLEAR_W-1:0]             clear_reg, clear_next;
    logic signed [WALL_ERR_W-1:0]   prev_wall_reg;
    logic signed [BLOB_ERR_W-1:0]   prev_red_reg;
    logic signed [BLOB_ERR_W-1:0]   prev_green_reg;

    // payload
    in_item_t                       item_reg;
    steer_mode_t                    mode_reg;
    logic signed [ERR_W-1:0]        err_reg;
    logic signed [ERR_W-1:0]        der_reg;
    logic [GAIN_W-1:0]              gain_p_reg;
    logic [GAIN_W-1:0]              gain_d_reg;
    logic [DIFF_W-1:0]              diff_reg;
    logic                           sat_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [WEIGHT_W-1:0]            q_reg;
    logic [WEIGHT_W-1:0]            weight_reg;
    logic [SPEED_W-1:0]             speed_reg;
    logic [ANGLE_W-1:0]             angle_reg;

    // decision and error terms
    logic                           red_seen;
    logic                           green_seen;
    logic                           seen;
    logic signed [WALL_ERR_W-1:0]   wall_err;
    logic signed [ERR_W-1:0]        wall_der;
    logic signed [BLOB_ERR_W-1:0]   red_err;
    logic signed [BLOB_ERR_W:0]     red_der;
    logic signed [BLOB_ERR_W-1:0]   green_err;
    logic signed [BLOB_ERR_W:0]     green_der;
    logic [AREA_W-1:0]              area_sel;
    logic [AREA_W-1:0]              thr_sel;
    logic [AREA_W-1:0]              diff_full;
    logic                           above;
    logic [REM_W-1:0]               rem;
    logic signed [ACC_W-1:0]        lo_sel;
    logic signed [ACC_W-1:0]        hi_sel;
    logic [ANGLE_W-1:0]             angle_int;
    logic [ANGLE_W-1:0]             angle_clamped;

    // obstacle detection and hold counter
    always_comb
    begin
        red_seen   = (item_reg.red_area > RED_THR) && (item_reg.red_area > item_reg.green_area);
        green_seen = (item_reg.green_area > GREEN_THR) &&
                     (item_reg.green_area > item_reg.red_area);
        seen       = red_seen | green_seen;

        if (seen)
            clear_next = '0;
        else if (clear_reg < CLEAR_TOP)
            clear_next = clear_reg + CLEAR_W'(1);
        else
            clear_next = clear_reg;

        avoid_next = seen | avoid_reg;
        if (clear_next >= HOLD)
            avoid_next = 1'b0;
        red_latch_next = seen ? red_seen : red_latch_reg;
    end

    // error and derivative of each loop
    always_comb
    begin
        wall_err  = {1'b0, item_reg.left_wall_area} - {1'b0, item_reg.right_wall_area};
        wall_der  = ERR_W'(wall_err) - ERR_W'(prev_wall_reg);
        red_err   = {1'b0, item_reg.red_x} - {1'b0, cfg.red_target_x};
        red_der   = (BLOB_ERR_W + 1)'(red_err) - (BLOB_ERR_W + 1)'(prev_red_reg);
        green_err = {1'b0, item_reg.green_x} - {1'b0, cfg.green_target_x};
        green_der = (BLOB_ERR_W + 1)'(green_err) - (BLOB_ERR_W + 1)'(prev_green_reg);

        area_sel  = red_latch_next ? item_reg.red_area : item_reg.green_area;
        thr_sel   = red_latch_next ? RED_THR : GREEN_THR;
        above     = area_sel > thr_sel;
        diff_full = area_sel - thr_sel;
    end

    // remainder check of the reciprocal weight estimate
    assign rem = REM_W'({diff_reg, WEIGHT_FRAC'(0)}) - mul_prod[REM_W-1:0];

    // angle clamp and truncation
    always_comb
    begin
        if (mode_reg == MODE_WALL)
        begin
            lo_sel    = LO_WALL;
            hi_sel    = HI_WALL;
            angle_int = acc_reg[WALL_FRAC +: ANGLE_W];
        end
        else
        begin
            lo_sel    = LO_AVOID;
            hi_sel    = HI_AVOID;
            angle_int = acc_reg[AVOID_FRAC +: ANGLE_W];
        end
        priority if (acc_reg < lo_sel)
            angle_clamped = A_LOW;
        else if (acc_reg > hi_sel)
            angle_clamped = A_HIGH;
        else
            angle_clamped = angle_int;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        mul_op.a   = '0;
        mul_op.b   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                mul_op.a   = MUL_A_W'(gain_p_reg);
                mul_op.b   = MUL_B_W'(err_reg);
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                mul_op.a   = MUL_A_W'(gain_d_reg);
                mul_op.b   = MUL_B_W'(der_reg);
                state_next = S_ADD_D;
            end
            S_ADD_D:
            begin
                state_next = (mode_reg == MODE_WALL) ? S_CLAMP : S_W_EST;
            end
            S_W_EST:
            begin
                mul_op.a   = MUL_A_W'(diff_reg);
                mul_op.b   = RECIP_B;
                state_next = S_W_BACK;
            end
            S_W_BACK:
            begin
                mul_op.a   = MUL_A_W'(mul_prod[WEIGHT_FRAC +: WEIGHT_W]);
                mul_op.b   = SPAN_B;
                state_next = S_W_FIX;
            end
            S_W_FIX:
            begin
                state_next = S_MUL_W;
            end
            S_MUL_W:
            begin
                mul_op.a   = MUL_A_W'(weight_reg);
                mul_op.b   = acc_reg[MUL_B_W-1:0];
                state_next = S_MUL_S;
            end
            S_MUL_S:
            begin
                mul_op.a   = MUL_A_W'(weight_reg);
                mul_op.b   = DROP_B;
                state_next = S_SPEED;
            end
            S_SPEED:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // loop state, updated once per frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avoid_reg      <= 1'b0;
            red_latch_reg  <= 1'b0;
            clear_reg      <= '0;
            prev_wall_reg  <= '0;
            prev_red_reg   <= '0;
            prev_green_reg <= '0;
        end
        else if (state_reg == S_DECIDE)
        begin
            avoid_reg     <= avoid_next;
            red_latch_reg <= red_latch_next;
            clear_reg     <= clear_next;
            if (!avoid_next)
                prev_wall_reg <= wall_err;
            else if (red_latch_next)
                prev_red_reg <= red_err;
            else
                prev_green_reg <= green_err;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    item_reg <= in_item;
            end
            S_DECIDE:
            begin
                weight_reg <= '0;
                speed_reg  <= FULL;
                sat_reg    <= above && (diff_full >= SPAN_AREA);
                diff_reg   <= above ? diff_full[DIFF_W-1:0] : '0;
                if (!avoid_next)
                begin
                    mode_reg   <= MODE_WALL;
                    err_reg    <= ERR_W'(wall_err);
                    der_reg    <= wall_der;
                    gain_p_reg <= cfg.wall_gain_p;
                    gain_d_reg <= cfg.wall_gain_d;
                    acc_reg    <= WALL_BASE;
                end
                else if (red_latch_next)
                begin
                    mode_reg   <= MODE_RED;
                    err_reg    <= ERR_W'(red_err);
                    der_reg    <= ERR_W'(red_der);
                    gain_p_reg <= cfg.red_gain_p;
                    gain_d_reg <= cfg.red_gain_d;
                    acc_reg    <= '0;
                end
                else
                begin
                    mode_reg   <= MODE_GREEN;
                    err_reg    <= ERR_W'(green_err);
                    der_reg    <= ERR_W'(green_der);
                    gain_p_reg <= cfg.green_gain_p;
                    gain_d_reg <= cfg.green_gain_d;
                    acc_reg    <= '0;
                end
            end
            S_MUL_D, S_ADD_D:
            begin
                acc_reg <= acc_reg + mul_prod;
            end
            S_W_BACK:
            begin
                q_reg <= mul_prod[WEIGHT_FRAC +: WEIGHT_W];
            end
            S_W_FIX:
            begin
                if (sat_reg)
                    weight_reg <= W_MAX;
                else
                    weight_reg <= q_reg + WEIGHT_W'(rem >= SPAN_REM);
            end
            S_MUL_S:
            begin
                acc_reg <= AVOID_BASE + mul_prod;
            end
            S_SPEED:
            begin
                speed_reg <= FULL - mul_prod[WEIGHT_FRAC +: SPEED_W];
            end
            S_CLAMP:
            begin
                angle_reg <= angle_clamped;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.mode   = mode_reg;
    assign res.angle  = angle_reg;
    assign res.speed  = speed_reg;
    assign res.weight = weight_reg;

    // checks
    `OAPDS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_DECIDE, "accepted request did not start the decision step")
    `OAPDS_ASSERT_IMPLY(a_hold_leaves_avoid, clear_reg >= HOLD, !avoid_reg, "avoid mode kept past the hold count")
    `OAPDS_ASSERT_IMPLY(a_angle_range, res_valid, (angle_reg >= A_LOW) && (angle_reg <= A_HIGH), "angle outside the clamp range")
    `OAPDS_ASSERT_IMPLY(a_wall_full_speed, res_valid && (mode_reg == MODE_WALL), (weight_reg == '0) && (speed_reg == FULL), "wall mode with weight or slowdown")
    `OAPDS_ASSERT_IMPLY(a_weight_cap, res_valid, (weight_reg <= W_MAX) && (speed_reg >= SLOWEST), "weight or speed out of range")

endmodule

// File: dv/steering_cmd_checker.sv
// command checker for the obstacle-aware pd steering block: watches the frame, command
// and apb channels, predicts each command and compares it field by field
// depends on oapds_pkg
`timescale 1ns / 1ps

module steering_cmd_checker
    import oapds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output int                     fail_count,
    output int                     cmds_pending
);

    // one predicted steering command
    typedef struct packed {
        steer_mode_t         mode;
        logic [ANGLE_W-1:0]  angle;
        logic [PULSE_W-1:0]  pulse;
        logic [SPEED_W-1:0]  speed;
        logic [WEIGHT_W-1:0] weight;
    } steer_cmd_t;

    steer_cmd_t expected_cmds[$];

    // shadow of the gains and targets, and of the steering state
    cfg_t regs;
    bit   avoiding;
    bit   red_latched;
    int   clear_run;
    int   wall_err_prev;
    int   red_err_prev;
    int   green_err_prev;

    // proximity weight in q1.16, limited to one
    function automatic longint proximity(int unsigned area, int unsigned thr);
        longint q;
        if (area <= thr)
            return 0;
        q = longint'(area - thr) * WEIGHT_ONE / WEIGHT_SPAN;
        return (q > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : q;
    endfunction

    // clamp a scaled angle to the servo range, then drop the fraction
    function automatic int angle_limit(longint v, int frac);
        longint lo;
        longint hi;
        lo = longint'(ANGLE_LOW) <<< frac;
        hi = longint'(ANGLE_HIGH) <<< frac;
        if (v < lo)
            return ANGLE_LOW;
        if (v > hi)
            return ANGLE_HIGH;
        return int'(v >>> frac);
    endfunction

    // obstacle decision, pd loop of the running mode, weight, speed and pulse
    function automatic steer_cmd_t predict_steering(in_item_t f);
        steer_cmd_t  c;
        int unsigned ra;
        int unsigned ga;
        bit          red_seen;
        bit          green_seen;
        int          err;
        int          der;
        int          ang;
        longint      pd;
        longint      w;
        ra = f.red_area;
        ga = f.green_area;
        red_seen   = (ra > RED_THRESHOLD_DEF) && (ra > ga);
        green_seen = (ga > GREEN_THRESHOLD_DEF) && (ga > ra);
        if (red_seen || green_seen)
        begin
            clear_run   = 0;
            avoiding    = 1'b1;
            red_latched = red_seen;
        end
        else if (clear_run < CLEAR_MAX)
            clear_run++;
        if (clear_run >= HOLD_FRAMES_DEF)
            avoiding = 1'b0;
        w = 0;
        if (avoiding)
        begin
            if (red_latched)
            begin
                err = int'(f.red_x) - int'(regs.red_target_x);
                der = err - red_err_prev;
                red_err_prev = err;
                w  = proximity(ra, RED_THRESHOLD_DEF);
                pd = longint'(regs.red_gain_p) * err + longint'(regs.red_gain_d) * der;
                c.mode = MODE_RED;
            end
            else
            begin
                err = int'(f.green_x) - int'(regs.green_target_x);
                der = err - green_err_prev;
                green_err_prev = err;
                w  = proximity(ga, GREEN_THRESHOLD_DEF);
                pd = longint'(regs.green_gain_p) * err + longint'(regs.green_gain_d) * der;
                c.mode = MODE_GREEN;
            end
            ang = angle_limit((longint'(CENTER_ANGLE_DEF) <<< AVOID_FRAC) + w * pd,
                              AVOID_FRAC);
            c.speed = SPEED_W'(FULL_SPEED - ((w * SPEED_DROP) >>> WEIGHT_FRAC));
        end
        else
        begin
            err = int'(f.left_wall_area) - int'(f.right_wall_area);
            der = err - wall_err_prev;
            wall_err_prev = err;
            pd = longint'(regs.wall_gain_p) * err + longint'(regs.wall_gain_d) * der;
            ang = angle_limit((longint'(CENTER_ANGLE_DEF) <<< WALL_FRAC) + pd, WALL_FRAC);
            c.speed = SPEED_W'(FULL_SPEED);
            c.mode  = MODE_WALL;
        end
        c.angle  = ANGLE_W'(ang);
        c.pulse  = PULSE_W'(PULSE_BASE + ang * PULSE_NUM / PULSE_DEN);
        c.weight = WEIGHT_W'(w);
        return c;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // results first, then register writes, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        in_item_t   f;
        steer_cmd_t e;
        if (!rst_n)
        begin
            expected_cmds.delete();
            fail_count           = 0;
            cmds_pending         = 0;
            regs.wall_gain_p     = WALL_GAIN_P_RST;
            regs.wall_gain_d     = WALL_GAIN_D_RST;
            regs.red_gain_p      = RED_GAIN_P_RST;
            regs.red_gain_d      = RED_GAIN_D_RST;
            regs.green_gain_p    = GREEN_GAIN_P_RST;
            regs.green_gain_d    = GREEN_GAIN_D_RST;
            regs.red_target_x    = RED_TARGET_RST;
            regs.green_target_x  = GREEN_TARGET_RST;
            avoiding             = 1'b0;
            red_latched          = 1'b0;
            clear_run            = 0;
            wall_err_prev        = 0;
            red_err_prev         = 0;
            green_err_prev       = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("command with no request outstanding: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    e = expected_cmds.pop_front();
                    check_field("steer_mode", e.mode, m_axis_tdata[1:0]);
                    check_field("steer_angle", e.angle, m_axis_tdata[8:2]);
                    check_field("servo_pulse_us", e.pulse, m_axis_tdata[19:9]);
                    check_field("motor_speed", e.speed, m_axis_tdata[27:20]);
                    check_field("proximity_weight", e.weight, m_axis_tdata[44:28]);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[4:2]))
                    REG_WALL_GAIN_P:    regs.wall_gain_p    = pwdata[GAIN_W-1:0];
                    REG_WALL_GAIN_D:    regs.wall_gain_d    = pwdata[GAIN_W-1:0];
                    REG_RED_GAIN_P:     regs.red_gain_p     = pwdata[GAIN_W-1:0];
                    REG_RED_GAIN_D:     regs.red_gain_d     = pwdata[GAIN_W-1:0];
                    REG_GREEN_GAIN_P:   regs.green_gain_p   = pwdata[GAIN_W-1:0];
                    REG_GREEN_GAIN_D:   regs.green_gain_d   = pwdata[GAIN_W-1:0];
                    REG_RED_TARGET_X:   regs.red_target_x   = pwdata[X_W-1:0];
                    REG_GREEN_TARGET_X: regs.green_target_x = pwdata[X_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                f.left_wall_area  = s_axis_tdata[17:0];
                f.right_wall_area = s_axis_tdata[35:18];
                f.red_area        = s_axis_tdata[53:36];
                f.red_x           = s_axis_tdata[63:54];
                f.green_area      = s_axis_tdata[81:64];
                f.green_x         = s_axis_tdata[91:82];
                expected_cmds.push_back(predict_steering(f));
            end
            cmds_pending = expected_cmds.size();
        end
    end

endmodule

// File: dv/obstacle_aware_pd_steering_top_tb.sv
// testbench top for the obstacle-aware pd steering block: clock, reset, frame and
// apb stimulus with random idling, and the verdict from the command checker
// depends on oapds_pkg, obstacle_aware_pd_steering_top, steering_cmd_checker
`timescale 1ns / 1ps

module obstacle_aware_pd_steering_top_tb;
    import oapds_pkg::*;

    localparam int AREA_MAX = 2**AREA_W - 1;
    localparam int X_MAX    = 2**X_W - 1;

    typedef enum int { RUN_RED, RUN_GREEN, RUN_CLEAR, RUN_NOISE } frame_run_t;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    // left_wall_area, right_wall_area, red_area, red_x, green_area, green_x
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    // steer_mode, steer_angle, servo_pulse_us, motor_speed, proximity_weight
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr          = '0;
    logic [APB_DATA_W-1:0]  pwdata         = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int          fail_count;
    int          cmds_pending;
    int          send_pct    = 0;
    int          recv_pct    = 0;
    int          hold_cycles = 0;
    frame_run_t  run_kind    = RUN_CLEAR;
    int          run_left    = 0;
    int unsigned red_aim     = RED_TARGET_RST;
    int unsigned green_aim   = GREEN_TARGET_RST;

    obstacle_aware_pd_steering_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    steering_cmd_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .cmds_pending  (cmds_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // command receiver, with random stalls and an occasional long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // run time limit
    initial
    begin
        #10_000_000;
        $display("obstacle_aware_pd_steering_top_tb: done, errors");
        $finish;
    end

    // offer one frame request, with random idle cycles ahead of it
    task automatic send_frame(input in_item_t f);
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, f.green_x, f.green_area, f.red_x, f.red_area,
                          f.right_wall_area, f.left_wall_area};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // apb write, junk above the register width now and then
    task automatic set_reg(input reg_index_t idx, input int unsigned val);
        int unsigned junk;
        junk = $urandom_range(1) ? $urandom : 0;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val | (junk << ((idx >= REG_RED_TARGET_X) ? X_W : GAIN_W));
        if (idx == REG_RED_TARGET_X)
            red_aim = val;
        if (idx == REG_GREEN_TARGET_X)
            green_aim = val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input cfg_t c);
        set_reg(REG_WALL_GAIN_P, c.wall_gain_p);
        set_reg(REG_WALL_GAIN_D, c.wall_gain_d);
        set_reg(REG_RED_GAIN_P, c.red_gain_p);
        set_reg(REG_RED_GAIN_D, c.red_gain_d);
        set_reg(REG_GREEN_GAIN_P, c.green_gain_p);
        set_reg(REG_GREEN_GAIN_D, c.green_gain_d);
        set_reg(REG_RED_TARGET_X, c.red_target_x);
        set_reg(REG_GREEN_TARGET_X, c.green_target_x);
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.wall_gain_p    = $urandom_range(0, 65535);
        c.wall_gain_d    = $urandom_range(0, 65535);
        c.red_gain_p     = $urandom_range(0, 65535);
        c.red_gain_d     = $urandom_range(0, 65535);
        c.green_gain_p   = $urandom_range(0, 65535);
        c.green_gain_d   = $urandom_range(0, 65535);
        c.red_target_x   = $urandom_range(0, X_MAX);
        c.green_target_x = $urandom_range(0, X_MAX);
        return c;
    endfunction

    // stop offering, then wait for every command and for the block to settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (cmds_pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // blob area that counts as an obstacle, biased to the weight edges
    function automatic int unsigned obstacle_area(int unsigned thr);
        case ($urandom_range(3))
            0:       return thr + $urandom_range(1, 200);
            1:       return thr + $urandom_range(1, WEIGHT_SPAN + 100);
            2:       return thr + $urandom_range(WEIGHT_SPAN - 5, WEIGHT_SPAN + 5);
            default: return $urandom_range(thr + 1, AREA_MAX);
        endcase
    endfunction

    // runs of obstacle frames and clear frames, with some pure noise
    function automatic in_item_t make_frame();
        in_item_t    f;
        int unsigned ra;
        int unsigned ga;
        if (run_left == 0)
        begin
            case ($urandom_range(9))
                0, 1, 2: run_kind = RUN_RED;
                3, 4, 5: run_kind = RUN_GREEN;
                6, 7, 8: run_kind = RUN_CLEAR;
                default: run_kind = RUN_NOISE;
            endcase
            run_left = (run_kind == RUN_CLEAR) ? $urandom_range(1, 14) : $urandom_range(1, 10);
        end
        run_left--;
        f.left_wall_area = $urandom_range(0, AREA_MAX);
        if ($urandom_range(1))
            f.right_wall_area = AREA_W'(int'(f.left_wall_area) + $urandom_range(0, 4000) - 2000);
        else
            f.right_wall_area = $urandom_range(0, AREA_MAX);
        if ($urandom_range(1))
            f.red_x = $urandom_range(0, X_MAX);
        else
            f.red_x = X_W'(red_aim + $urandom_range(0, 80) - 40);
        if ($urandom_range(1))
            f.green_x = $urandom_range(0, X_MAX);
        else
            f.green_x = X_W'(green_aim + $urandom_range(0, 80) - 40);
        case (run_kind)
            RUN_RED:
            begin
                ra = obstacle_area(RED_THRESHOLD_DEF);
                ga = $urandom_range(0, ra - 1);
            end
            RUN_GREEN:
            begin
                ga = obstacle_area(GREEN_THRESHOLD_DEF);
                ra = $urandom_range(0, ga - 1);
            end
            RUN_CLEAR:
            begin
                // equal large blobs count as no obstacle
                if ($urandom_range(7) == 0)
                begin
                    ra = $urandom_range(GREEN_THRESHOLD_DEF + 1, AREA_MAX);
                    ga = ra;
                end
                else
                begin
                    ra = $urandom_range(0, RED_THRESHOLD_DEF);
                    ga = $urandom_range(0, GREEN_THRESHOLD_DEF);
                end
            end
            default:
            begin
                ra = $urandom_range(0, AREA_MAX);
                ga = $urandom_range(0, AREA_MAX);
            end
        endcase
        f.red_area   = ra;
        f.green_area = ga;
        return f;
    endfunction

    task automatic run_frames(input int n);
        for (int i = 0; i < n; i++)
            send_frame(make_frame());
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames under the reset gains
        send_pct = 13;
        recv_pct = 48;
        send_frame('{18'd0, 18'd0, 18'd0, 10'd0, 18'd0, 10'd0});
        send_frame('{18'h3FFFF, 18'd0, 18'd0, 10'd0, 18'd0, 10'd0});
        send_frame('{18'd0, 18'h3FFFF, 18'd0, 10'd0, 18'd0, 10'd0});
        // red exactly at threshold, then just over, then full weight
        send_frame('{18'd100, 18'd90, 18'd900, 10'd500, 18'd0, 10'd0});
        send_frame('{18'd0, 18'd0, 18'd901, 10'd0, 18'd0, 10'd0});
        send_frame('{18'd0, 18'd0, 18'd3400, 10'h3FF, 18'd0, 10'd0});
        send_frame('{18'd0, 18'd0, 18'h3FFFF, 10'h3FF, 18'd0, 10'd0});
        // eight clear frames leave avoid mode on the last one
        repeat (8)
            send_frame('{18'd1000, 18'd2000, 18'd0, 10'd0, 18'd0, 10'd0});
        // green at threshold, just over, equal to red, full weight, then red just over green and all fields at maximum
        send_frame('{18'd0, 18'd0, 18'd0, 10'd0, 18'd2200, 10'd600});
        send_frame('{18'd0, 18'd0, 18'd0, 10'd0, 18'd2201, 10'd0});
        send_frame('{18'd0, 18'd0, 18'd5000, 10'd0, 18'd5000, 10'd0});
        send_frame('{18'd0, 18'd0, 18'd0, 10'd0, 18'd4700, 10'h3FF});
        send_frame('{18'd0, 18'd0, 18'd5000, 10'd0, 18'd4999, 10'd60});
        send_frame('{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 10'h3FF, 18'h3FFFF, 10'h3FF});
        drain();

        // random gains; receiver holds off while frames keep coming
        load_config(random_config());
        run_frames(200);
        hold_cycles = 400;
        run_frames(350);
        drain();

        // largest gains and opposite target extremes, idling swapped
        send_pct = 48;
        recv_pct = 13;
        load_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      10'h3FF, 10'h000});
        run_frames(250);
        drain();
        run_frames(300);
        drain();

        // no idling: zero gains, then random gains
        send_pct = 0;
        recv_pct = 0;
        load_config('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'h000, 10'h3FF});
        run_frames(100);
        drain();
        load_config(random_config());
        run_frames(450);
        drain();

        if (fail_count == 0)
            $display("obstacle_aware_pd_steering_top_tb: done, clean");
        else
            $display("obstacle_aware_pd_steering_top_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/oapds_pkg.sv
src/oapds_cfg.sv
src/oapds_mul.sv
src/oapds_seq.sv
src/obstacle_aware_pd_steering_top.sv
dv/steering_cmd_checker.sv
dv/obstacle_aware_pd_steering_top_tb.sv
